// ===== rtl/scd_pkg.sv =====
package scd_pkg;

    localparam int VECTOR_DIM  = 3;
    localparam int NUM_AXES    = 3;
    localparam int FIX_W       = 32;
    localparam int MASS_W      = 31;
    localparam int LIM_W       = 31;
    localparam int CFG_IDX_W   = 2;
    localparam int FRAC_Q      = 16;
    localparam int FRAC_U      = 30;
    localparam int OVF_SHIFT   = FIX_W - 1 - FRAC_Q;
    localparam int OVF_W       = MASS_W + OVF_SHIFT + 1;

    localparam int DIV_STEPS   = 31;
    localparam int DIV_DEN_W   = 33;
    localparam int DIV_REM_W   = DIV_DEN_W + 1;

    localparam int SHIFT_STEPS = 5;
    localparam int SQRT_STEPS  = 32;
    localparam int SQRT_REM_W  = 35;
    localparam int NORM_LAT    = 5 + SHIFT_STEPS + SQRT_STEPS;

    localparam int DOT_LAT     = 4;
    localparam int LANE_LAT    = DOT_LAT + 4;
    localparam int LATENCY     = 1 + NORM_LAT + DIV_STEPS + 1 + LANE_LAT;

    typedef logic signed [FIX_W-1:0]   fix_t;
    typedef logic        [FIX_W-1:0]   mag_t;
    typedef logic signed [2*FIX_W-1:0] prod_t;
    typedef logic        [2*FIX_W-1:0] ssum_t;
    typedef logic        [MASS_W-1:0]  mass_t;
    typedef logic        [LIM_W-1:0]   lim_t;
    typedef logic        [DIV_REM_W-1:0] drem_t;
    typedef logic        [DIV_DEN_W-1:0] dden_t;
    typedef logic        [DIV_STEPS-1:0] dquo_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE  = 2'd0,
        CFG_MAX_LIN = 2'd1,
        CFG_MAX_ANG = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        mass_t                       mass;
        mag_t [NUM_AXES-1:0]         fabs;
        logic [NUM_AXES-1:0]         fneg;
        logic [NUM_AXES-1:0]         ovf;
        logic [NUM_AXES-1:0]         vneg;
    } side_a_t;

    typedef struct packed {
        logic [NUM_AXES-1:0]         fneg;
        logic [NUM_AXES-1:0]         ovf;
        logic [NUM_AXES-1:0]         vneg;
        logic                        nz;
    } side_b_t;

    localparam lim_t LIM_RESET = lim_t'(32768);
    localparam fix_t FIX_MAX   = 32'sh7FFF_FFFF;
    localparam fix_t FIX_MIN   = 32'sh8000_0000;

    // saturate a 33-bit sum to 32 signed bits
    function automatic fix_t sat33(input logic signed [FIX_W:0] x);
        if (x[FIX_W] != x[FIX_W-1])
            return x[FIX_W] ? FIX_MIN : FIX_MAX;
        return fix_t'(x[FIX_W-1:0]);
    endfunction

    // floor divide by 2^30, then saturate
    function automatic fix_t sat_shr30(input prod_t x);
        prod_t sh;
        sh = x >>> FRAC_U;
        if (sh > prod_t'(FIX_MAX))
            return FIX_MAX;
        if (sh < prod_t'(FIX_MIN))
            return FIX_MIN;
        return fix_t'(sh[FIX_W-1:0]);
    endfunction

    function automatic fix_t clamp_lim(input fix_t x, input lim_t lim);
        logic signed [FIX_W:0] xe;
        logic signed [FIX_W:0] le;
        logic signed [FIX_W:0] nl;
        xe = {x[FIX_W-1], x};
        le = {2'b00, lim};
        nl = -le;
        if (xe > le)
            return fix_t'(le[FIX_W-1:0]);
        if (xe < nl)
            return fix_t'(nl[FIX_W-1:0]);
        return x;
    endfunction

endpackage

// ===== rtl/scd_div.sv =====
module scd_div (
    input  logic           clk,
    input  logic           adv,
    input  scd_pkg::drem_t rem_in,
    input  scd_pkg::dden_t den_in,
    input  scd_pkg::dquo_t bits_in,
    output scd_pkg::dquo_t quo
);
    import scd_pkg::*;

    drem_t rem_reg  [DIV_STEPS];
    dden_t den_reg  [DIV_STEPS];
    dquo_t bits_reg [DIV_STEPS];
    dquo_t quo_reg  [DIV_STEPS];

    drem_t rem_src  [DIV_STEPS];
    dden_t den_src  [DIV_STEPS];
    dquo_t bits_src [DIV_STEPS];
    dquo_t quo_src  [DIV_STEPS];

    drem_t rem_next [DIV_STEPS];
    dquo_t quo_next [DIV_STEPS];

    assign rem_src[0]  = rem_in;
    assign den_src[0]  = den_in;
    assign bits_src[0] = bits_in;
    assign quo_src[0]  = '0;

    // one quotient bit per stage
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        if (k > 0) begin : g_src
            assign rem_src[k]  = rem_reg[k-1];
            assign den_src[k]  = den_reg[k-1];
            assign bits_src[k] = bits_reg[k-1];
            assign quo_src[k]  = quo_reg[k-1];
        end

        always_comb
        begin
            drem_t r2;
            r2 = {rem_src[k][DIV_REM_W-2:0], bits_src[k][DIV_STEPS-1]};
            if (r2 >= {1'b0, den_src[k]})
            begin
                rem_next[k] = r2 - {1'b0, den_src[k]};
                quo_next[k] = {quo_src[k][DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = r2;
                quo_next[k] = {quo_src[k][DIV_STEPS-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= rem_next[k];
                den_reg[k]  <= den_src[k];
                bits_reg[k] <= bits_src[k] << 1;
                quo_reg[k]  <= quo_next[k];
            end
        end
    end

    assign quo = quo_reg[DIV_STEPS-1];

endmodule

// ===== rtl/scd_norm.sv =====
module scd_norm (
    input  logic          clk,
    input  logic          adv,
    input  scd_pkg::fix_t v    [scd_pkg::NUM_AXES],
    output scd_pkg::mag_t norm,
    output scd_pkg::mag_t av   [scd_pkg::NUM_AXES]
);
    import scd_pkg::*;

    mag_t  abs_reg [NUM_AXES];
    mag_t  max_next;
    mag_t  w_reg   [SHIFT_STEPS+1];
    mag_t  sv_reg  [SHIFT_STEPS+1][NUM_AXES];
    mag_t  w_next  [SHIFT_STEPS];
    mag_t  sv_next [SHIFT_STEPS][NUM_AXES];
    ssum_t sq_reg  [NUM_AXES];
    mag_t  av7_reg [NUM_AXES];
    ssum_t s01_reg;
    ssum_t sq2_reg;
    mag_t  av8_reg [NUM_AXES];
    ssum_t ss_reg;
    mag_t  av9_reg [NUM_AXES];

    logic [SQRT_REM_W-1:0] rem_reg  [SQRT_STEPS];
    mag_t                  root_reg [SQRT_STEPS];
    ssum_t                 x_reg    [SQRT_STEPS];
    mag_t                  avq_reg  [SQRT_STEPS][NUM_AXES];
    logic [SQRT_REM_W-1:0] rem_src  [SQRT_STEPS];
    mag_t                  root_src [SQRT_STEPS];
    ssum_t                 x_src    [SQRT_STEPS];
    mag_t                  avq_src  [SQRT_STEPS][NUM_AXES];
    logic [SQRT_REM_W-1:0] rem_next [SQRT_STEPS];
    mag_t                  root_next[SQRT_STEPS];

    // magnitudes, then the largest of them
    always_ff @(posedge clk)
    begin
        if (adv)
            for (int i = 0; i < NUM_AXES; i++)
                abs_reg[i] <= v[i][FIX_W-1] ? mag_t'(-v[i]) : mag_t'(v[i]);
    end

    always_comb
    begin
        max_next = abs_reg[0];
        for (int i = 1; i < NUM_AXES; i++)
            if (abs_reg[i] > max_next)
                max_next = abs_reg[i];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_reg[0]  <= max_next;
            sv_reg[0] <= abs_reg;
        end
    end

    // normalise: shift all components until the largest reaches bit 30
    for (genvar j = 0; j < SHIFT_STEPS; j++) begin : g_shift
        localparam int SH = 1 << (SHIFT_STEPS - 1 - j);

        always_comb
        begin
            if (w_reg[j][FIX_W-1 -: SH+1] == '0)
            begin
                w_next[j] = w_reg[j] << SH;
                for (int i = 0; i < NUM_AXES; i++)
                    sv_next[j][i] = sv_reg[j][i] << SH;
            end
            else
            begin
                w_next[j]  = w_reg[j];
                sv_next[j] = sv_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                w_reg[j+1]  <= w_next[j];
                sv_reg[j+1] <= sv_next[j];
            end
        end
    end

    // squares and their sum
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NUM_AXES; i++)
                sq_reg[i] <= sv_reg[SHIFT_STEPS][i] * sv_reg[SHIFT_STEPS][i];
            av7_reg <= sv_reg[SHIFT_STEPS];
            s01_reg <= sq_reg[0] + sq_reg[1];
            sq2_reg <= sq_reg[2];
            av8_reg <= av7_reg;
            ss_reg  <= s01_reg + sq2_reg;
            av9_reg <= av8_reg;
        end
    end

    // integer square root, one result bit per stage
    assign rem_src[0]  = '0;
    assign root_src[0] = '0;
    assign x_src[0]    = ss_reg;
    assign avq_src[0]  = av9_reg;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        if (k > 0) begin : g_src
            assign rem_src[k]  = rem_reg[k-1];
            assign root_src[k] = root_reg[k-1];
            assign x_src[k]    = x_reg[k-1];
            assign avq_src[k]  = avq_reg[k-1];
        end

        always_comb
        begin
            logic [SQRT_REM_W-1:0] r2;
            logic [SQRT_REM_W-1:0] trial;
            r2    = {1'b0, rem_src[k][SQRT_REM_W-4:0], x_src[k][2*FIX_W-1 -: 2]};
            trial = {1'b0, root_src[k], 2'b01};
            if (r2 >= trial)
            begin
                rem_next[k]  = r2 - trial;
                root_next[k] = {root_src[k][FIX_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = r2;
                root_next[k] = {root_src[k][FIX_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                x_reg[k]    <= x_src[k] << 2;
                avq_reg[k]  <= avq_src[k];
            end
        end
    end

    assign norm = root_reg[SQRT_STEPS-1];
    assign av   = avq_reg[SQRT_STEPS-1];

endmodule

// ===== rtl/scd_lane.sv =====
module scd_lane (
    input  logic           clk,
    input  logic           adv,
    input  scd_pkg::fix_t  p,
    input  scd_pkg::fix_t  u,
    input  scd_pkg::fix_t  dot,
    input  scd_pkg::lim_t  max_lin,
    input  scd_pkg::lim_t  max_ang,
    output scd_pkg::prod_t prod,
    output scd_pkg::fix_t  accel
);
    import scd_pkg::*;

    prod_t prod_reg;
    fix_t  pd_reg [DOT_LAT];
    fix_t  ud_reg [DOT_LAT];
    prod_t lprod_reg;
    fix_t  p1_reg;
    fix_t  lin_reg;
    fix_t  p2_reg;
    fix_t  ang_reg;
    fix_t  linc_reg;
    fix_t  accel_reg;

    logic signed [FIX_W:0] diff;
    logic signed [FIX_W:0] total;
    fix_t                  ang_c;

    always_comb
    begin
        diff  = {p2_reg[FIX_W-1], p2_reg} - {lin_reg[FIX_W-1], lin_reg};
        ang_c = clamp_lim(ang_reg, max_ang);
        total = {linc_reg[FIX_W-1], linc_reg} + {ang_c[FIX_W-1], ang_c};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // term of the dot product; hold p and u until the dot returns
            prod_reg  <= p * u;
            pd_reg[0] <= p;
            ud_reg[0] <= u;
            for (int k = 1; k < DOT_LAT; k++)
            begin
                pd_reg[k] <= pd_reg[k-1];
                ud_reg[k] <= ud_reg[k-1];
            end
            lprod_reg <= dot * ud_reg[DOT_LAT-1];
            p1_reg    <= pd_reg[DOT_LAT-1];
            lin_reg   <= sat_shr30(lprod_reg);
            p2_reg    <= p1_reg;
            ang_reg   <= sat33(diff);
            linc_reg  <= clamp_lim(lin_reg, max_lin);
            accel_reg <= sat33(total);
        end
    end

    assign prod  = prod_reg;
    assign accel = accel_reg;

endmodule

// ===== rtl/split_clamp_acceleration.sv =====
// Split-and-clamp acceleration. Each transaction carries an agent's unsigned mass and
// its velocity and force in signed Q16.16; the block returns force/mass split into a part
// along the unit velocity and a part across it, each clamped per component to its own
// limit, then summed with saturation. One transaction is taken every clock cycle unless
// the output stalls; its result passes through the velocity normalisation with its
// 32-stage square root followed by the 31-stage dividers, three lanes working side by
// side. While the enable register is clear, transactions are consumed and give no result.
// A stalled output freezes the whole pipeline; limits and enable are written through a
// simple write port (0 enable, 1 linear limit, 2 angular limit); the user must do so
// only while the block is idle, and the block itself does not enforce this.
module split_clamp_acceleration (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  scd_pkg::mass_t                mass,
    input  scd_pkg::fix_t                 velocity_x,
    input  scd_pkg::fix_t                 velocity_y,
    input  scd_pkg::fix_t                 velocity_z,
    input  scd_pkg::fix_t                 force_x,
    input  scd_pkg::fix_t                 force_y,
    input  scd_pkg::fix_t                 force_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output scd_pkg::fix_t                 accel_x,
    output scd_pkg::fix_t                 accel_y,
    output scd_pkg::fix_t                 accel_z,
    input  logic                          cfg_write_en,
    input  logic [scd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [scd_pkg::LIM_W-1:0]     cfg_data
);
    import scd_pkg::*;

    logic    adv;
    logic    enable_reg;
    lim_t    max_lin_reg;
    lim_t    max_ang_reg;
    logic    vld_reg [LATENCY];

    fix_t    vin [NUM_AXES];
    fix_t    fin [NUM_AXES];
    mass_t   mass_reg;
    fix_t    v_reg    [NUM_AXES];
    mag_t    fabs_reg [NUM_AXES];
    logic    fneg_reg [NUM_AXES];

    side_a_t side_a_next;
    side_a_t side_a_reg [NORM_LAT];
    side_a_t sa;
    side_b_t side_b_next;
    side_b_t side_b_reg [DIV_STEPS];
    side_b_t sb;

    mag_t    norm;
    mag_t    av_n   [NUM_AXES];
    dquo_t   quo_p  [NUM_AXES];
    dquo_t   quo_u  [NUM_AXES];
    dquo_t   m_u    [NUM_AXES];
    fix_t    p_reg  [NUM_AXES];
    fix_t    u_reg  [NUM_AXES];
    prod_t   prod   [NUM_AXES];
    fix_t    accel_l[NUM_AXES];
    prod_t   psum_reg;
    prod_t   pz_reg;
    prod_t   sum_reg;
    fix_t    dot_reg;

    // the whole pipeline advances unless a finished result is held at the output
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b1;
            max_lin_reg <= LIM_RESET;
            max_ang_reg <= LIM_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_ENABLE:  enable_reg  <= cfg_data[0];
                CFG_MAX_LIN: max_lin_reg <= cfg_data;
                CFG_MAX_ANG: max_ang_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // valid bits travel with the data; a disabled transaction enters as a bubble
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LATENCY; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid && enable_reg;
            for (int k = 1; k < LATENCY; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    assign out_valid = vld_reg[LATENCY-1];

    // input register; drop the z axis in a planar build
    always_comb
    begin
        vin[0] = velocity_x;
        vin[1] = velocity_y;
        vin[2] = (VECTOR_DIM >= 3) ? velocity_z : '0;
        fin[0] = force_x;
        fin[1] = force_y;
        fin[2] = (VECTOR_DIM >= 3) ? force_z : '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mass_reg <= mass;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                v_reg[i]    <= vin[i];
                fabs_reg[i] <= fin[i][FIX_W-1] ? mag_t'(-fin[i]) : mag_t'(fin[i]);
                fneg_reg[i] <= fin[i][FIX_W-1];
            end
        end
    end

    // Force side data waits while the velocity is normalised. The quotient
    // |f|*2^16/mass reaches 2^31 exactly when |f| >= mass*2^15, which also
    // covers a zero mass with a non-zero force.
    always_comb
    begin
        side_a_next.mass = mass_reg;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            side_a_next.fabs[i] = fabs_reg[i];
            side_a_next.fneg[i] = fneg_reg[i];
            side_a_next.vneg[i] = v_reg[i][FIX_W-1];
            side_a_next.ovf[i]  = (fabs_reg[i] != '0) &&
                                  (OVF_W'(fabs_reg[i]) >= (OVF_W'(mass_reg) << OVF_SHIFT));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_a_reg[0] <= side_a_next;
            for (int k = 1; k < NORM_LAT; k++)
                side_a_reg[k] <= side_a_reg[k-1];
        end
    end

    assign sa = side_a_reg[NORM_LAT-1];

    scd_norm u_norm (
        .clk  (clk),
        .adv  (adv),
        .v    (v_reg),
        .norm (norm),
        .av   (av_n)
    );

    // Dividers per axis. Force/mass: remainder starts from the bits above the
    // 31 quotient bits; a zero mass divides by one so that a zero force gives
    // zero. Velocity/norm: each scaled component is at most the norm, so the
    // quotient never exceeds 1.0 in Q2.30.
    for (genvar i = 0; i < NUM_AXES; i++) begin : g_div
        scd_div u_div_p (
            .clk     (clk),
            .adv     (adv),
            .rem_in  (drem_t'(sa.fabs[i] >> OVF_SHIFT)),
            .den_in  (dden_t'(sa.mass) | dden_t'(sa.mass == '0)),
            .bits_in ({sa.fabs[i][OVF_SHIFT-1:0], {FRAC_Q{1'b0}}}),
            .quo     (quo_p[i])
        );

        scd_div u_div_u (
            .clk     (clk),
            .adv     (adv),
            .rem_in  (drem_t'(av_n[i] >> 1)),
            .den_in  (dden_t'(norm)),
            .bits_in ({av_n[i][0], {FRAC_U{1'b0}}}),
            .quo     (quo_u[i])
        );
    end

    always_comb
    begin
        side_b_next.fneg = sa.fneg;
        side_b_next.ovf  = sa.ovf;
        side_b_next.vneg = sa.vneg;
        side_b_next.nz   = (norm != '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_b_reg[0] <= side_b_next;
            for (int k = 1; k < DIV_STEPS; k++)
                side_b_reg[k] <= side_b_reg[k-1];
        end
    end

    assign sb = side_b_reg[DIV_STEPS-1];

    // apply signs and saturation to the quotients; a zero norm gives no direction
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
            m_u[i] = sb.nz ? quo_u[i] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                if (sb.ovf[i])
                    p_reg[i] <= sb.fneg[i] ? FIX_MIN : FIX_MAX;
                else
                    p_reg[i] <= sb.fneg[i] ? -fix_t'(quo_p[i]) : fix_t'(quo_p[i]);
                u_reg[i] <= sb.vneg[i] ? -fix_t'(m_u[i]) : fix_t'(m_u[i]);
            end
        end
    end

    for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
        scd_lane u_lane (
            .clk     (clk),
            .adv     (adv),
            .p       (p_reg[i]),
            .u       (u_reg[i]),
            .dot     (dot_reg),
            .max_lin (max_lin_reg),
            .max_ang (max_ang_reg),
            .prod    (prod[i]),
            .accel   (accel_l[i])
        );
    end

    // merge the lane products into the dot product, back to Q16.16
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            psum_reg <= prod[0] + prod[1];
            pz_reg   <= prod[2];
            sum_reg  <= psum_reg + pz_reg;
            dot_reg  <= sat_shr30(sum_reg);
        end
    end

    assign accel_x = accel_l[0];
    assign accel_y = accel_l[1];
    assign accel_z = (VECTOR_DIM >= 3) ? accel_l[2] : '0;

    // a transaction taken enters the pipeline valid exactly when enabled
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (vld_reg[0] == $past(enable_reg)))
        else $error("accepted transaction did not enter the pipeline correctly");

    // nothing enters when no transaction was taken
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_valid && !in_stall) |=> !vld_reg[0])
        else $error("pipeline gained an item without a transaction");

    // the input is held back only by a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result waiting");

endmodule

// ===== dv/split_clamp_acceleration_tb.sv =====
module split_clamp_acceleration_tb;
    import scd_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    mass_t       mass;
    fix_t        velocity_x;
    fix_t        velocity_y;
    fix_t        velocity_z;
    fix_t        force_x;
    fix_t        force_y;
    fix_t        force_z;
    logic        out_valid;
    logic        out_stall;
    fix_t        accel_x;
    fix_t        accel_y;
    fix_t        accel_z;
    logic        cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LIM_W-1:0]     cfg_data;

    typedef struct {
        fix_t ax;
        fix_t ay;
        fix_t az;
    } accel_vec_t;

    // Accelerations still owed by the block, oldest first
    accel_vec_t accel_owed[$];

    // Shadow copy of the configuration registers
    bit   shadow_enable;
    lim_t shadow_lin_lim;
    lim_t shadow_ang_lim;

    int   mismatches;
    bit   leftover;
    bit   quiet_sender;   // hold off all sender idling when set
    bit   quiet_receiver; // hold off all receiver idling when set

    split_clamp_acceleration i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mass         (mass),
        .velocity_x   (velocity_x),
        .velocity_y   (velocity_y),
        .velocity_z   (velocity_z),
        .force_x      (force_x),
        .force_y      (force_y),
        .force_z      (force_z),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Watchdog: the slowest correct run is well below this
    initial
    begin
        #40000000;
        $display("split_clamp_acceleration_tb: errors");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Predictor helpers
    // ---------------------------------------------------------------------

    function automatic longint sat_fix(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    // Floor division by 2^30: arithmetic shift does exactly that
    function automatic longint floor_q30(input longint x);
        return x >>> 30;
    endfunction

    function automatic longint clamp_to(input longint x, input longint lim);
        if (x > lim)
            return lim;
        if (x < -lim)
            return -lim;
        return x;
    endfunction

    // Integer square root, floor, of a 64-bit unsigned value (bit by bit)
    function automatic longint unsigned root_floor(input longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Work out the acceleration for one transaction
    function automatic accel_vec_t predict_accel(input mass_t m, input fix_t vx,
                                                 input fix_t vy, input fix_t vz,
                                                 input fix_t fx, input fix_t fy,
                                                 input fix_t fz);
        longint          vel[3];
        longint          frc[3];
        longint          pref[3];
        longint          unitv[3];
        longint unsigned avel[3];
        longint unsigned peak;
        longint unsigned sumsq;
        longint unsigned vnorm;
        longint unsigned quo;
        longint unsigned frc_mag;
        longint          dotp;
        longint          lin;
        longint          ang;
        longint          res[3];
        int              shift;
        accel_vec_t      r;
        vel[0] = vx; vel[1] = vy; vel[2] = (VECTOR_DIM >= 3) ? longint'(vz) : 0;
        frc[0] = fx; frc[1] = fy; frc[2] = (VECTOR_DIM >= 3) ? longint'(fz) : 0;
        for (int i = 0; i < 3; i++)
        begin
            if (m == 0)
                pref[i] = frc[i] > 0 ? 64'sd2147483647 : (frc[i] < 0 ? -64'sd2147483648 : 0);
            else
            begin
                frc_mag = frc[i] < 0 ? longint'(-frc[i]) : longint'(frc[i]);
                quo = (frc_mag << 16) / longint'(m);
                if (frc[i] < 0)
                    pref[i] = quo >= 64'h8000_0000 ? -64'sd2147483648 : -longint'(quo);
                else
                    pref[i] = quo >= 64'h7FFF_FFFF ? 64'sd2147483647 : longint'(quo);
            end
        end
        peak = 0;
        for (int i = 0; i < 3; i++)
        begin
            avel[i] = vel[i] < 0 ? longint'(-vel[i]) : longint'(vel[i]);
            if (avel[i] > peak)
                peak = avel[i];
        end
        shift = 0;
        while (peak != 0 && peak < 64'h4000_0000)
        begin
            peak = peak << 1;
            shift++;
        end
        sumsq = 0;
        for (int i = 0; i < 3; i++)
        begin
            avel[i] = avel[i] << shift;
            sumsq   = sumsq + avel[i] * avel[i];
        end
        vnorm = root_floor(sumsq);
        for (int i = 0; i < 3; i++)
        begin
            quo = 0;
            if (vnorm != 0)
            begin
                quo = (avel[i] << 30) / vnorm;
                if (quo > 64'h4000_0000)
                    quo = 64'h4000_0000;
            end
            unitv[i] = vel[i] < 0 ? -longint'(quo) : longint'(quo);
        end
        dotp = 0;
        for (int i = 0; i < 3; i++)
            dotp = dotp + pref[i] * unitv[i];
        dotp = sat_fix(floor_q30(dotp));
        for (int i = 0; i < 3; i++)
        begin
            lin    = sat_fix(floor_q30(dotp * unitv[i]));
            ang    = sat_fix(pref[i] - lin);
            lin    = clamp_to(lin, longint'(shadow_lin_lim));
            ang    = clamp_to(ang, longint'(shadow_ang_lim));
            res[i] = (i < 2 || VECTOR_DIM >= 3) ? sat_fix(lin + ang) : 0;
        end
        r.ax = fix_t'(res[0]);
        r.ay = fix_t'(res[1]);
        r.az = fix_t'(res[2]);
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Result side: random stall, compare each transaction with oldest owed
    // ---------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= quiet_receiver ? 1'b0 : ($urandom_range(0, 99) < 35);
    end

    always @(posedge clk)
    begin
        accel_vec_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (accel_owed.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h %h %h", accel_x, accel_y, accel_z);
            end
            else
            begin
                want = accel_owed.pop_front();
                if (want.ax !== accel_x || want.ay !== accel_y || want.az !== accel_z)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h %h %h, got %h %h %h",
                                 want.ax, want.ay, want.az, accel_x, accel_y, accel_z);
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sender and configuration tasks
    // ---------------------------------------------------------------------

    // Offer one transaction, hold it until taken, queue its prediction
    task automatic send_item(input mass_t m, input fix_t vx, input fix_t vy,
                             input fix_t vz, input fix_t fx, input fix_t fy,
                             input fix_t fz);
        while (!quiet_sender && $urandom_range(0, 99) < 35)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        mass       <= m;
        velocity_x <= vx;
        velocity_y <= vy;
        velocity_z <= vz;
        force_x    <= fx;
        force_y    <= fy;
        force_z    <= fz;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (shadow_enable)
            accel_owed.push_back(predict_accel(m, vx, vy, vz, fx, fy, fz));
    endtask

    // Drop valid and wait until every owed result is back, then let the
    // pipeline drain any transaction that gives no result
    task automatic drain;
        in_valid <= 1'b0;
        while (accel_owed.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input lim_t value);
        drain();
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            CFG_ENABLE:  shadow_enable  = value[0];
            CFG_MAX_LIN: shadow_lin_lim = value;
            CFG_MAX_ANG: shadow_ang_lim = value;
            default: ;
        endcase
    endtask

    function automatic fix_t rand_fix();
        case ($urandom_range(0, 5))
            0: return fix_t'($urandom_range(0, 4) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF);
            1: return fix_t'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            2: return 0;
            default: return fix_t'($urandom);
        endcase
    endfunction

    function automatic mass_t rand_mass();
        case ($urandom_range(0, 4))
            0: return mass_t'($urandom_range(1, 1 << 17));
            1: return mass_t'($urandom_range(0, 3));
            default: return mass_t'($urandom);
        endcase
    endfunction

    function automatic lim_t rand_lim();
        case ($urandom_range(0, 3))
            0: return lim_t'($urandom_range(0, 1 << 18));
            1: return {LIM_W{1'b1}};
            default: return lim_t'($urandom);
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int k = 0; k < count; k++)
            send_item(rand_mass(), rand_fix(), rand_fix(), rand_fix(),
                      rand_fix(), rand_fix(), rand_fix());
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Field extremes and the named special cases, at reset limits, then wide and zero limits
    task automatic test_directed;
        send_item(mass_t'(32'h10000), 0, 0, 0, 32'sh10000, -32'sh20000, 32'sh30000);
        send_item(0, 32'sh10000, 0, 0, 32'sh10000, -32'sh10000, 0);
        send_item(0, 0, 0, 0, 0, 0, 0);
        send_item({MASS_W{1'b1}}, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX);
        send_item(1, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN);
        send_item(1, FIX_MAX, FIX_MIN, 0, FIX_MIN, FIX_MAX, -1);
        send_item(mass_t'(32'h10000), 32'sh10000, 0, 0, 32'sh8000, 0, 0);
        send_item(mass_t'(32'h10000), 0, 32'sh10000, 0, 0, -32'sh4000, 32'sh4000);
        send_item(mass_t'(32'h10000), 1, 1, 1, 32'sh1000, 32'sh1000, -32'sh1000);
        send_item(mass_t'(32'h8000), -1, 0, 0, -1, 1, 0);
        send_item(mass_t'(32'h10000), 0, 0, FIX_MIN, 0, 0, FIX_MAX);
        // Wide limits so saturation of the sum shows
        write_reg(CFG_MAX_LIN, {LIM_W{1'b1}});
        write_reg(CFG_MAX_ANG, {LIM_W{1'b1}});
        send_item(1, FIX_MAX, 0, 0, FIX_MAX, FIX_MAX, FIX_MAX);
        send_item(1, FIX_MIN, FIX_MAX, 0, FIX_MIN, FIX_MIN, FIX_MAX);
        send_item(mass_t'(32'h10000), 32'sh10000, 32'sh10000, 0, 32'sh30000, 0, 0);
        // Zero limits: everything clamps to zero
        write_reg(CFG_MAX_LIN, 0);
        write_reg(CFG_MAX_ANG, 0);
        send_item(mass_t'(32'h10000), 32'sh10000, 0, 0, 32'sh10000, 32'sh10000, 0);
    endtask

    // Disabled block consumes transactions and gives nothing
    task automatic test_disable;
        write_reg(CFG_ENABLE, 0);
        send_random(20);
        write_reg(CFG_ENABLE, 1);
        send_random(10);
    endtask

    // Random transactions through a number of limit settings
    task automatic test_random;
        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(CFG_MAX_LIN, rand_lim());
            write_reg(CFG_MAX_ANG, rand_lim());
            // one phase runs flat out with no idling on either side
            quiet_sender   = (phase == 3);
            quiet_receiver = (phase == 3);
            send_random(230);
        end
        quiet_sender   = 1'b0;
        quiet_receiver = 1'b0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        mass           = '0;
        velocity_x     = '0;
        velocity_y     = '0;
        velocity_z     = '0;
        force_x        = '0;
        force_y        = '0;
        force_z        = '0;
        cfg_write_en   = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        mismatches     = 0;
        quiet_sender   = 1'b0;
        quiet_receiver = 1'b0;
        shadow_enable  = 1'b1;
        shadow_lin_lim = LIM_RESET;
        shadow_ang_lim = LIM_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_disable();
        test_random();

        // Wait for the tail, bounded, then drain the pipeline
        in_valid <= 1'b0;
        for (int w = 0; w < 200000 && accel_owed.size() != 0; w++)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        leftover = (accel_owed.size() != 0);
        if (mismatches == 0 && !leftover)
            $display("split_clamp_acceleration_tb: clean");
        else
            $display("split_clamp_acceleration_tb: errors");
        $finish;
    end

endmodule
